/* design/rde_pkg.sv */
// Shared types, constants and a helper function for the raster draw engine.
`timescale 1ns / 1ps
package rde_pkg;
	localparam int SCREEN_WIDTH_DEF = 320;
	localparam int SCREEN_HEIGHT_DEF = 200;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_RECT  = 2'd1,
		FUNC_LINE  = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		REG_CAMERA_X = 1'b0,
		REG_CAMERA_Y = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
		logic signed [15:0] line_x0;
		logic signed [15:0] line_y0;
		logic signed [15:0] line_x1;
		logic signed [15:0] line_y1;
		logic [23:0]        color_rgb;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  read_value;
		logic        read_in_range;
		logic [15:0] pixels_written;
	} res_t;

	// Work handed from the front to the back. Coordinates are screen space.
	typedef struct packed {
		func_t              func;
		logic [1:0]         shade;
		logic signed [18:0] xa;
		logic signed [18:0] ya;
		logic signed [18:0] xb;
		logic signed [18:0] yb;
		logic               empty;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RUN,
		BK_READ,
		BK_READ_WAIT,
		BK_DONE
	} back_state_t;

	// Rounds a Q12.4 value half away from zero.
	function automatic logic signed [18:0] q4_round(input logic signed [15:0] v);
		logic [16:0] m;
		logic [16:0] n;
		begin
			m = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
			n = (m + 17'd8) >> 4;
			q4_round = v[15] ? -$signed({2'b00, n}) : $signed({2'b00, n});
		end
	endfunction
endpackage

/* design/raster_draw_engine.sv */
// Top level of the raster draw engine: register port, front, queue and back.
`timescale 1ns / 1ps
// A command passes the two front-end registers and the queue, then the back end walks
// its pixels (a line counts its off-screen steps too) and then raises done.
// A read passes the read and read-wait states; an empty job goes straight to done.
// One command at a time: a new one is taken only once the back end is idle again.
// After reset a clearing pass zeroes every pixel while busy stays high.
// Each result word is shown for one cycle on done; the receiver cannot stall.
module raster_draw_engine #(
	parameter int SCREEN_WIDTH = rde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = rde_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rde_pkg::cmd_t cmd,
	output logic          done,
	output rde_pkg::res_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import rde_pkg::*;

	logic signed [15:0] camera_x_q, camera_y_q;
	logic               f_valid, q_full, q_ne, pop, bk_idle;
	job_t               f_job, q_job;
	logic [1:0]         inflight_q;
	logic               accept;

	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_CAMERA_X) ? 32'($signed(camera_x_q))
		: 32'($signed(camera_y_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_y_q <= '0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (reg_idx_t'(paddr[2]))
				REG_CAMERA_X: camera_x_q <= pwdata[15:0];
				REG_CAMERA_Y: camera_y_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// One command in flight at a time keeps the front end free of stalls.
	assign accept = start && !busy;
	assign busy = (inflight_q != '0) || !bk_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (accept) begin
			inflight_q <= 2'd1;
		end else if (pop) begin
			inflight_q <= '0;
		end
	end

	rde_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .cmd(cmd),
		.camera_x(camera_x_q), .camera_y(camera_y_q),
		.out_valid(f_valid), .job(f_job), .out_ready(!q_full)
	);

	rde_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_data(f_job), .full(q_full),
		.pop(pop), .not_empty(q_ne), .pop_data(q_job)
	);

	rde_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_ne), .job(q_job), .job_pop(pop),
		.idle(bk_idle), .done(done), .result(result)
	);

	top_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");
	top_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while not busy");
	top_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> bk_idle)
		else $error("command taken while the back end was working");
endmodule

/* design/rde_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rde_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* design/rde_front.sv */
// Command front end: shade quantization, camera offset, rounding and clipping.
`timescale 1ns / 1ps
module rde_front #(
	parameter int SCREEN_WIDTH = rde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = rde_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rde_pkg::cmd_t      cmd,
	input  logic signed [15:0] camera_x,
	input  logic signed [15:0] camera_y,
	output logic               out_valid,
	output rde_pkg::job_t      job,
	input  logic               out_ready
);
	import rde_pkg::*;

	logic               v_s1;
	cmd_t               cmd_s1;
	logic [15:0]        lum_sum_s1;
	logic               v_s2;
	job_t               job_s2;
	job_t               job_d;
	logic [1:0]         shade;
	logic signed [18:0] rx0, ry0, rx1, ry1;
	logic signed [18:0] x0, y0, x1, y1;
	logic signed [18:0] xe, ye;
	logic               adv;

	assign adv = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
			lum_sum_s1 <= 16'(cmd.color_rgb[23:16]) * 16'd30
				+ 16'(cmd.color_rgb[15:8]) * 16'd59
				+ 16'(cmd.color_rgb[7:0]) * 16'd11;
			job_s2 <= job_d;
		end
	end

	// Dividing by 100 then dropping six bits is the same as dividing by 6400.
	always_comb begin
		if (lum_sum_s1 >= 16'd19200) begin
			shade = 2'd3;
		end else if (lum_sum_s1 >= 16'd12800) begin
			shade = 2'd2;
		end else if (lum_sum_s1 >= 16'd6400) begin
			shade = 2'd1;
		end else begin
			shade = 2'd0;
		end
	end

	always_comb begin
		rx0 = q4_round(cmd_s1.line_x0);
		ry0 = q4_round(cmd_s1.line_y0);
		rx1 = q4_round(cmd_s1.line_x1);
		ry1 = q4_round(cmd_s1.line_y1);
		job_d.func = func_t'(cmd_s1.func);
		job_d.shade = shade;
		job_d.empty = 1'b0;
		x0 = '0;
		y0 = '0;
		x1 = '0;
		y1 = '0;
		xe = '0;
		ye = '0;
		case (func_t'(cmd_s1.func))
			FUNC_CLEAR: begin
				x1 = 19'(SCREEN_WIDTH);
				y1 = 19'(SCREEN_HEIGHT);
			end
			FUNC_RECT: begin
				x0 = 19'(cmd_s1.pos_x) + 19'(camera_x);
				y0 = 19'(cmd_s1.pos_y) + 19'(camera_y);
				xe = x0 + 19'(cmd_s1.rect_w);
				ye = y0 + 19'(cmd_s1.rect_h);
				x1 = (xe > 19'(SCREEN_WIDTH)) ? 19'(SCREEN_WIDTH) : xe;
				y1 = (ye > 19'(SCREEN_HEIGHT)) ? 19'(SCREEN_HEIGHT) : ye;
				if (x0 < 0) x0 = '0;
				if (y0 < 0) y0 = '0;
				job_d.empty = (cmd_s1.rect_w <= 0) || (cmd_s1.rect_h <= 0)
					|| (x0 >= x1) || (y0 >= y1);
			end
			FUNC_LINE: begin
				x0 = rx0 + 19'(camera_x);
				y0 = ry0 + 19'(camera_y);
				x1 = rx1 + 19'(camera_x);
				y1 = ry1 + 19'(camera_y);
			end
			FUNC_READ: begin
				x0 = 19'(cmd_s1.pos_x);
				y0 = 19'(cmd_s1.pos_y);
				job_d.empty = (x0 < 0) || (x0 >= 19'(SCREEN_WIDTH)) || (y0 < 0)
					|| (y0 >= 19'(SCREEN_HEIGHT));
			end
			default: ;
		endcase
		job_d.xa = x0;
		job_d.ya = y0;
		job_d.xb = x1;
		job_d.yb = y1;
	end

	assign out_valid = v_s2;
	assign job = job_s2;
endmodule

/* design/rde_queue.sv */
// Short FIFO of classified jobs between the front end and the back end.
`timescale 1ns / 1ps
module rde_queue #(
	parameter int DEPTH = rde_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rde_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output rde_pkg::job_t pop_data
);
	import rde_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          slots_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full = cnt_q == (AW + 1)'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW + 1)'(push && !full) - (AW + 1)'(pop && not_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_q] <= push_data;
		end
	end
endmodule

/* design/rde_back.sv */
// Back end: rectangle sweep, Bresenham walker, pixel read and clearing pass.
`timescale 1ns / 1ps
module rde_back #(
	parameter int SCREEN_WIDTH = rde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = rde_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  rde_pkg::job_t job,
	output logic          job_pop,
	output logic          idle,
	output logic          done,
	output rde_pkg::res_t result
);
	import rde_pkg::*;

	localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = $clog2(PIX);

	back_state_t        state_q, state_d;
	job_t               job_q;
	logic signed [18:0] x_q, y_q;
	logic signed [20:0] err_q;
	logic [16:0]        cnt_q;
	logic [AW-1:0]      row_base_q;
	logic               init_q;
	logic [AW-1:0]      addr;
	logic               we;
	logic [1:0]         wdata;
	logic [1:0]         rdata;
	logic signed [18:0] dx, dy;
	logic signed [20:0] e2;
	logic               on_screen;
	logic               last;
	logic               take;

	rde_ram #(.WIDTH(2), .DEPTH(PIX)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign dx = (job_q.xb > job_q.xa) ? job_q.xb - job_q.xa : job_q.xa - job_q.xb;
	assign dy = (job_q.yb > job_q.ya) ? job_q.yb - job_q.ya : job_q.ya - job_q.yb;
	assign e2 = err_q <<< 1;
	assign on_screen = (x_q >= 0) && (x_q < 19'(SCREEN_WIDTH)) && (y_q >= 0)
		&& (y_q < 19'(SCREEN_HEIGHT));
	assign take = (state_q == BK_IDLE) && job_valid && !init_q;
	assign job_pop = take;
	assign idle = (state_q == BK_IDLE) && !init_q;

	always_comb begin
		if (job_q.func == FUNC_LINE) begin
			last = (x_q == job_q.xb) && (y_q == job_q.yb);
		end else begin
			last = (x_q == job_q.xb - 1) && (y_q == job_q.yb - 1);
		end
	end

	always_comb begin
		addr = row_base_q + AW'(x_q);
		if (job_q.func == FUNC_LINE) begin
			addr = AW'(y_q * SCREEN_WIDTH) + AW'(x_q);
		end
		we = 1'b0;
		wdata = job_q.shade;
		if (init_q) begin
			we = 1'b1;
			wdata = '0;
		end else if (state_q == BK_RUN) begin
			we = (job_q.func == FUNC_LINE) ? on_screen : 1'b1;
		end
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					state_d = job.empty ? BK_DONE : (job.func == FUNC_READ ? BK_READ : BK_RUN);
				end
			end
			BK_RUN: if (last) state_d = BK_DONE;
			BK_READ: state_d = BK_READ_WAIT;
			BK_READ_WAIT: state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			init_q <= 1'b1;
			x_q <= '0;
			y_q <= '0;
			row_base_q <= '0;
		end else begin
			state_q <= state_d;
			if (init_q) begin
				// Clearing pass after reset, one pixel a cycle.
				if (x_q == 19'(SCREEN_WIDTH - 1)) begin
					x_q <= '0;
					row_base_q <= row_base_q + AW'(SCREEN_WIDTH);
					if (y_q == 19'(SCREEN_HEIGHT - 1)) begin
						init_q <= 1'b0;
						y_q <= '0;
						row_base_q <= '0;
					end else begin
						y_q <= y_q + 1;
					end
				end else begin
					x_q <= x_q + 1;
				end
			end else if (take) begin
				x_q <= job.xa;
				y_q <= job.ya;
				row_base_q <= AW'(job.ya * SCREEN_WIDTH);
			end else if (state_q == BK_RUN && !last) begin
				if (job_q.func == FUNC_LINE) begin
					if (e2 > -21'(dy)) x_q <= x_q + ((job_q.xa < job_q.xb) ? 19'sd1 : -19'sd1);
					if (e2 < 21'(dx)) y_q <= y_q + ((job_q.ya < job_q.yb) ? 19'sd1 : -19'sd1);
				end else if (x_q == job_q.xb - 1) begin
					x_q <= job_q.xa;
					y_q <= y_q + 1;
					row_base_q <= row_base_q + AW'(SCREEN_WIDTH);
				end else begin
					x_q <= x_q + 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job;
			cnt_q <= '0;
			err_q <= 21'(((job.xb > job.xa) ? job.xb - job.xa : job.xa - job.xb))
				- 21'(((job.yb > job.ya) ? job.yb - job.ya : job.ya - job.yb));
		end else if (state_q == BK_RUN) begin
			if (we && cnt_q != 17'h1FFFF) cnt_q <= cnt_q + 1'b1;
			if (job_q.func == FUNC_LINE) begin
				err_q <= err_q - ((e2 > -21'(dy)) ? 21'(dy) : '0)
					+ ((e2 < 21'(dx)) ? 21'(dx) : '0);
			end
		end
	end

	assign done = state_q == BK_DONE;
	always_comb begin
		result.read_value = '0;
		result.read_in_range = 1'b0;
		result.pixels_written = (cnt_q > 17'hFFFF) ? 16'hFFFF : cnt_q[15:0];
		if (job_q.func == FUNC_READ) begin
			result.pixels_written = '0;
			result.read_in_range = !job_q.empty;
			result.read_value = job_q.empty ? 2'd0 : rdata;
		end else if (job_q.empty) begin
			result.pixels_written = '0;
		end
	end

	rde_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ_WAIT |-> $past(state_q) == BK_READ)
		else $error("read wait entered out of order");
	rde_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ || state_q == BK_DONE) && !init_q |-> !we)
		else $error("store written outside a draw");
	rde_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q != BK_IDLE)
		else $error("job taken without leaving idle");
endmodule
